// ----- rtl/core/priority_led_blink_sequencer_defines.svh -----
// Assertion macros for the priority LED blink sequencer.
`ifndef PRIORITY_LED_BLINK_SEQUENCER_DEFINES_SVH
`define PRIORITY_LED_BLINK_SEQUENCER_DEFINES_SVH
`ifndef SYNTH
`define PLBS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PLBS_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define PLBS_ASSERT(lbl, prop, msg)
`define PLBS_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// ----- rtl/core/plbs_pkg.sv -----
// Types, constants and profile ROM of the priority LED blink sequencer.
package plbs_pkg;

	localparam int NUM_PROFILES = 11;

	localparam logic [3:0] NO_PROFILE = 4'd11;
	localparam logic [7:0] SOLID      = 8'd255;

	localparam logic [1:0] PH_ON  = 2'd0;
	localparam logic [1:0] PH_OFF = 2'd1;
	localparam logic [1:0] PH_GAP = 2'd2;

	localparam logic [1:0] RATE_NORMAL = 2'd0;
	localparam logic [1:0] RATE_SLOW   = 2'd1;
	localparam logic [1:0] RATE_QUICK  = 2'd2;

	localparam logic MODE_ONCE = 1'b0;

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_EVENT = 1'b1;

	localparam logic [1:0] ALT_NONE = 2'd0;
	localparam logic [1:0] ALT_RG   = 2'd1;
	localparam logic [1:0] ALT_TEST = 2'd2;

	localparam logic [3:0] PROF_BOOT = 4'd0;
	localparam logic [3:0] PROF_RG   = 4'd1;
	localparam logic [3:0] PROF_DIM  = 4'd8;

	localparam logic [1:0] REG_ON_TICKS    = 2'd0;
	localparam logic [1:0] REG_CYCLE_TICKS = 2'd1;
	localparam logic [1:0] REG_GAP_TICKS   = 2'd2;
	localparam logic [1:0] REG_BRIGHTNESS  = 2'd3;

	localparam logic [15:0] GAP_SINGLE = 16'd10;
	// floor(x/10) = (x * DIV10_MUL) >> DIV10_SHIFT for any 16-bit x
	localparam logic [15:0] DIV10_MUL   = 16'd52429;
	localparam int          DIV10_SHIFT = 19;

	typedef struct packed {
		logic       mode;
		logic [1:0] rate;
		logic [7:0] times;
		logic       r;
		logic       g;
		logic       b;
	} prof_t;

	typedef struct packed {
		logic       op;
		logic [3:0] profile_id;
		logic       enable;
		logic       test;
	} item_t;

	typedef struct packed {
		logic [13:0] on_ticks;
		logic [13:0] cycle_ticks;
		logic [15:0] gap_ticks;
		logic [15:0] brightness;
	} cfg_t;

	typedef struct packed {
		logic [NUM_PROFILES-1:0] run;
		logic [3:0]              cur;
		logic [1:0]              phase;
		logic [15:0]             timer;
		logic [7:0]              left;
		logic [15:0]             on_per;
		logic [15:0]             cyc_per;
		logic [15:0]             gap_per;
		logic [1:0]              alt;
		logic [15:0]             lvl_r;
		logic [15:0]             lvl_g;
		logic [15:0]             lvl_b;
		logic [15:0]             drv_r;
		logic [15:0]             drv_g;
		logic [15:0]             drv_b;
	} seq_state_t;

	function automatic prof_t prof_rom(input logic [3:0] p);
		prof_t q;
		case (p)
			4'd0:    q = '{1'b0, RATE_QUICK,  8'd4,   1'b1, 1'b1, 1'b1};
			4'd1:    q = '{1'b1, RATE_SLOW,   8'd3,   1'b1, 1'b0, 1'b0};
			4'd2:    q = '{1'b1, RATE_SLOW,   8'd1,   1'b0, 1'b1, 1'b0};
			4'd3:    q = '{1'b1, RATE_NORMAL, 8'd1,   1'b0, 1'b1, 1'b0};
			4'd4:    q = '{1'b1, RATE_NORMAL, 8'd2,   1'b1, 1'b0, 1'b0};
			4'd5:    q = '{1'b1, RATE_NORMAL, 8'd3,   1'b1, 1'b0, 1'b0};
			4'd6:    q = '{1'b1, RATE_NORMAL, 8'd5,   1'b1, 1'b0, 1'b0};
			4'd7:    q = '{1'b1, RATE_NORMAL, 8'd0,   1'b0, 1'b0, 1'b0};
			4'd8:    q = '{1'b1, RATE_NORMAL, 8'd1,   1'b1, 1'b1, 1'b0};
			4'd9:    q = '{1'b1, RATE_NORMAL, SOLID,  1'b1, 1'b0, 1'b0};
			4'd10:   q = '{1'b1, RATE_NORMAL, SOLID,  1'b0, 1'b1, 1'b0};
			default: q = '0;
		endcase
		return q;
	endfunction

endpackage

// ----- rtl/core/plbs_next.sv -----
// Next-state logic: run flag update, priority scan, profile load and blink machine.
module plbs_next (
	input  plbs_pkg::seq_state_t st,
	input  plbs_pkg::item_t      item,
	input  plbs_pkg::cfg_t       cfg,
	output plbs_pkg::seq_state_t nx
);

	localparam int NUM_P = plbs_pkg::NUM_PROFILES;

	plbs_pkg::prof_t             q;
	plbs_pkg::prof_t             lq;
	logic                        do_scan;
	logic                        found;
	logic [3:0]                  pick;
	logic [NUM_P-1:0]            id_mask;
	logic [NUM_P-1:0]            cur_mask;
	logic [31:0]                 div_prod;
	logic [15:0]                 gap_div10;
	logic [1:0]                  ld_alt;
	logic [15:0]                 lum;

	assign q         = plbs_pkg::prof_rom(st.cur);
	assign lq        = plbs_pkg::prof_rom(pick);
	assign id_mask   = NUM_P'(1) << item.profile_id;
	assign cur_mask  = NUM_P'(1) << st.cur;
	assign div_prod  = 32'(cfg.gap_ticks) * 32'(plbs_pkg::DIV10_MUL);
	assign gap_div10 = 16'(div_prod >> plbs_pkg::DIV10_SHIFT);
	assign lum       = cfg.brightness;

	always_comb begin
		nx      = st;
		do_scan = 1'b0;
		found   = 1'b0;
		pick    = plbs_pkg::NO_PROFILE;
		ld_alt  = plbs_pkg::ALT_NONE;

		if (item.op == plbs_pkg::OP_EVENT) begin
			if (item.profile_id < 4'(NUM_P)) begin
				if (item.enable)
					nx.run = st.run | id_mask;
				else
					nx.run = st.run & ~id_mask;
			end
			do_scan = 1'b1;
		end else begin
			if (st.timer != 16'hFFFF)
				nx.timer = st.timer + 16'd1;
			if (st.cur < 4'(NUM_P) && q.times != plbs_pkg::SOLID && q.times != 8'd0) begin
				case (st.phase)
					plbs_pkg::PH_ON: begin
						if (nx.timer > st.on_per) begin
							nx.drv_r = '0;
							nx.drv_b = '0;
							nx.drv_g = (st.alt == plbs_pkg::ALT_RG) ? st.lvl_r : '0;
							nx.left  = st.left - 8'd1;
							nx.phase = plbs_pkg::PH_OFF;
						end
					end
					plbs_pkg::PH_OFF: begin
						if (nx.timer > st.cyc_per) begin
							if (st.left != 8'd0) begin
								nx.drv_r = st.lvl_r;
								nx.drv_g = st.lvl_g;
								nx.drv_b = st.lvl_b;
								nx.timer = '0;
								nx.phase = plbs_pkg::PH_ON;
							end else begin
								if (st.alt == plbs_pkg::ALT_RG)
									nx.drv_g = '0;
								nx.timer = '0;
								nx.phase = plbs_pkg::PH_GAP;
							end
						end
					end
					plbs_pkg::PH_GAP: begin
						if (nx.timer > st.gap_per) begin
							if (q.mode == plbs_pkg::MODE_ONCE) begin
								nx.run  = st.run & ~cur_mask;
								do_scan = 1'b1;
							end else begin
								nx.drv_r = st.lvl_r;
								nx.drv_g = st.lvl_g;
								nx.drv_b = st.lvl_b;
								nx.left  = q.times;
								nx.timer = '0;
								nx.phase = plbs_pkg::PH_ON;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end

		// lowest set run flag wins
		for (int i = NUM_P - 1; i >= 0; i--) begin
			if (nx.run[i]) begin
				found = 1'b1;
				pick  = 4'(i);
			end
		end

		if (pick == plbs_pkg::PROF_RG)
			ld_alt = plbs_pkg::ALT_RG;
		else if (pick == plbs_pkg::PROF_BOOT && item.test)
			ld_alt = plbs_pkg::ALT_TEST;

		if (do_scan) begin
			if (!found) begin
				nx.cur   = plbs_pkg::NO_PROFILE;
				nx.drv_r = '0;
				nx.drv_g = '0;
				nx.drv_b = '0;
			end else if (pick != st.cur) begin
				nx.cur  = pick;
				nx.left = lq.times;
				nx.alt  = ld_alt;

				nx.lvl_r = lq.r ? lum : '0;
				nx.lvl_b = lq.b ? lum : '0;
				if (pick == plbs_pkg::PROF_DIM) begin
					nx.lvl_g = lq.g ? (lum >> 1) : '0;
				end else if (ld_alt == plbs_pkg::ALT_TEST) begin
					nx.lvl_g = '0;
					nx.lvl_b = '0;
				end else begin
					nx.lvl_g = lq.g ? lum : '0;
				end

				case (lq.rate)
					plbs_pkg::RATE_SLOW: begin
						if (ld_alt == plbs_pkg::ALT_RG) begin
							nx.on_per  = 16'(cfg.on_ticks) << 1;
							nx.cyc_per = 16'(cfg.cycle_ticks) << 1;
						end else begin
							nx.on_per  = 16'(cfg.on_ticks) << 2;
							nx.cyc_per = 16'(cfg.cycle_ticks) << 2;
						end
					end
					plbs_pkg::RATE_NORMAL: begin
						nx.on_per  = 16'(cfg.on_ticks);
						nx.cyc_per = (lq.times == plbs_pkg::SOLID) ?
							16'(cfg.on_ticks) : 16'(cfg.cycle_ticks);
					end
					plbs_pkg::RATE_QUICK: begin
						nx.on_per  = 16'(cfg.on_ticks >> 2);
						nx.cyc_per = 16'(cfg.cycle_ticks >> 2);
					end
					default: begin
					end
				endcase

				if (lq.times == plbs_pkg::SOLID)
					nx.gap_per = '0;
				else if (lq.times == 8'd1)
					nx.gap_per = plbs_pkg::GAP_SINGLE;
				else if (pick == plbs_pkg::PROF_BOOT)
					nx.gap_per = gap_div10;
				else
					nx.gap_per = cfg.gap_ticks;

				nx.drv_r = nx.lvl_r;
				nx.drv_g = nx.lvl_g;
				nx.drv_b = nx.lvl_b;
				nx.timer = '0;
				nx.phase = plbs_pkg::PH_ON;
			end
		end
	end

endmodule

// ----- rtl/core/priority_led_blink_sequencer.sv -----
// Top level of the priority LED blink sequencer: handshakes, state, config registers.
// Takes one transaction per clock, back to back, unless a stalled result holds it; each
// accepted one waits in the item register, and the edge that advances it applies it to
// the sequencer state in a single pass of logic (flag update, priority scan over 11
// profiles, profile load, blink step). The result (RGB compare values and loaded profile)
// is valid from that edge until taken. While it waits, the item register takes one more.
// Configuration registers are latched into the state only when a profile loads; write them
// only while no transaction is in flight. After reset no profile is loaded and outputs are 0.
`include "priority_led_blink_sequencer_defines.svh"

module priority_led_blink_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        op,
	input  logic [3:0]  profile_id,
	input  logic        enable,
	input  logic        test_button_active,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [15:0] pwm_red,
	output logic [15:0] pwm_green,
	output logic [15:0] pwm_blue,
	output logic [3:0]  active_profile,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	plbs_pkg::cfg_t       cfg_q;
	plbs_pkg::item_t      item_s1;
	logic                 valid_s1;
	plbs_pkg::seq_state_t st_q;
	plbs_pkg::seq_state_t st_nx;
	logic                 res_valid_q;
	logic                 adv;
	logic                 cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.on_ticks    <= 14'd250;
			cfg_q.cycle_ticks <= 14'd500;
			cfg_q.gap_ticks   <= 16'd1000;
			cfg_q.brightness  <= 16'd1000;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				plbs_pkg::REG_ON_TICKS:    cfg_q.on_ticks    <= pwdata[13:0];
				plbs_pkg::REG_CYCLE_TICKS: cfg_q.cycle_ticks <= pwdata[13:0];
				plbs_pkg::REG_GAP_TICKS:   cfg_q.gap_ticks   <= pwdata[15:0];
				plbs_pkg::REG_BRIGHTNESS:  cfg_q.brightness  <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			plbs_pkg::REG_ON_TICKS:    prdata = 32'(cfg_q.on_ticks);
			plbs_pkg::REG_CYCLE_TICKS: prdata = 32'(cfg_q.cycle_ticks);
			plbs_pkg::REG_GAP_TICKS:   prdata = 32'(cfg_q.gap_ticks);
			plbs_pkg::REG_BRIGHTNESS:  prdata = 32'(cfg_q.brightness);
			default:                   prdata = '0;
		endcase
	end

	// item register advances into the state whenever the result slot is free
	assign adv        = valid_s1 & ~(res_valid_q & result_stall);
	assign item_stall = valid_s1 & ~adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!item_stall)
			valid_s1 <= item_valid;
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1.op         <= op;
			item_s1.profile_id <= profile_id;
			item_s1.enable     <= enable;
			item_s1.test       <= test_button_active;
		end
	end

	plbs_next u_next (
		.st   (st_q),
		.item (item_s1),
		.cfg  (cfg_q),
		.nx   (st_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{cur: plbs_pkg::NO_PROFILE, phase: plbs_pkg::PH_ON, default: '0};
		end else if (adv) begin
			st_q <= st_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (adv)
			res_valid_q <= 1'b1;
		else if (!result_stall)
			res_valid_q <= 1'b0;
	end

	assign result_valid   = res_valid_q;
	assign pwm_red        = st_q.drv_r;
	assign pwm_green      = st_q.drv_g;
	assign pwm_blue       = st_q.drv_b;
	assign active_profile = st_q.cur;

	`PLBS_ASSERT(a_dark_when_idle, (st_q.cur == plbs_pkg::NO_PROFILE) |-> (st_q.drv_r == '0 && st_q.drv_g == '0 && st_q.drv_b == '0), "outputs lit with no profile loaded")
	`PLBS_ASSERT(a_loaded_is_running, (st_q.cur != plbs_pkg::NO_PROFILE) |-> (|(st_q.run & (11'(1) << st_q.cur))), "loaded profile has no run flag")
	`PLBS_ASSERT(a_hold_when_stalled, !adv |=> $stable(st_q), "state changed without a transaction")
	`PLBS_ASSERT_NEVER(a_phase_code, st_q.phase != plbs_pkg::PH_ON && st_q.phase != plbs_pkg::PH_OFF && st_q.phase != plbs_pkg::PH_GAP, "blink phase out of range")
	`PLBS_ASSERT(a_stall_needs_full, item_stall |-> (valid_s1 && res_valid_q), "item stalled with room downstream")

endmodule

// ----- verif/tb_priority_led_blink_sequencer.sv -----
// Self-checking testbench for the priority LED blink sequencer: directed and random traffic.
module tb_priority_led_blink_sequencer;
	import plbs_pkg::*;

	localparam logic MODE_REPEAT = 1'b1;
	localparam int QUIET_LIMIT = 1000;

	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic [3:0]  profile;
	} led_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic        op = OP_TICK;
	logic [3:0]  profile_id = 4'd0;
	logic        enable = 1'b0;
	logic        test_button_active = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [15:0] pwm_red;
	logic [15:0] pwm_green;
	logic [15:0] pwm_blue;
	logic [3:0]  active_profile;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = 4'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	priority_led_blink_sequencer uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.op(op),
		.profile_id(profile_id),
		.enable(enable),
		.test_button_active(test_button_active),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.pwm_red(pwm_red),
		.pwm_green(pwm_green),
		.pwm_blue(pwm_blue),
		.active_profile(active_profile),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #4 clk = ~clk;

	prof_t led_table [0:NUM_PROFILES-1] = '{
		'{MODE_ONCE,   RATE_QUICK,  8'd4, 1'b1, 1'b1, 1'b1},
		'{MODE_REPEAT, RATE_SLOW,   8'd3, 1'b1, 1'b0, 1'b0},
		'{MODE_REPEAT, RATE_SLOW,   8'd1, 1'b0, 1'b1, 1'b0},
		'{MODE_REPEAT, RATE_NORMAL, 8'd1, 1'b0, 1'b1, 1'b0},
		'{MODE_REPEAT, RATE_NORMAL, 8'd2, 1'b1, 1'b0, 1'b0},
		'{MODE_REPEAT, RATE_NORMAL, 8'd3, 1'b1, 1'b0, 1'b0},
		'{MODE_REPEAT, RATE_NORMAL, 8'd5, 1'b1, 1'b0, 1'b0},
		'{MODE_REPEAT, RATE_NORMAL, 8'd0, 1'b0, 1'b0, 1'b0},
		'{MODE_REPEAT, RATE_NORMAL, 8'd1, 1'b1, 1'b1, 1'b0},
		'{MODE_REPEAT, RATE_NORMAL, SOLID, 1'b1, 1'b0, 1'b0},
		'{MODE_REPEAT, RATE_NORMAL, SOLID, 1'b0, 1'b1, 1'b0}
	};

	// predicted sequencer state
	logic [13:0] c_on = 14'd250;
	logic [13:0] c_cyc = 14'd500;
	logic [15:0] c_gap = 16'd1000;
	logic [15:0] c_bright = 16'd1000;
	logic [NUM_PROFILES-1:0] m_run = '0;
	logic [3:0]  m_cur = NO_PROFILE;
	logic [1:0]  m_phase = PH_ON;
	logic [15:0] m_timer = 16'd0;
	logic [7:0]  m_left = 8'd0;
	logic [15:0] m_on = 16'd0;
	logic [15:0] m_cyc = 16'd0;
	logic [15:0] m_gap = 16'd0;
	logic [1:0]  m_alt = ALT_NONE;
	logic [15:0] m_lvl [3] = '{16'd0, 16'd0, 16'd0};
	logic [15:0] m_drv [3] = '{16'd0, 16'd0, 16'd0};

	led_out_t expected_leds [$];
	led_out_t want;
	int fail_count = 0;
	int burst_left = 0;
	int stall_mode = 0;
	int stall_left = 0;
	int quiet_cycles = 0;

	function automatic void led_load(input int p, input logic t);
		prof_t q;
		int k;
		q = led_table[p];
		m_cur = 4'(p);
		m_left = q.times;
		if (4'(p) == PROF_RG)
			m_alt = ALT_RG;
		else if (4'(p) == PROF_BOOT && t)
			m_alt = ALT_TEST;
		else
			m_alt = ALT_NONE;
		m_lvl[0] = q.r ? c_bright : 16'd0;
		m_lvl[2] = q.b ? c_bright : 16'd0;
		if (4'(p) == PROF_DIM) begin
			m_lvl[1] = q.g ? (c_bright >> 1) : 16'd0;
		end else if (m_alt == ALT_TEST) begin
			m_lvl[1] = 16'd0;
			m_lvl[2] = 16'd0;
		end else begin
			m_lvl[1] = q.g ? c_bright : 16'd0;
		end
		if (q.rate == RATE_SLOW) begin
			k = (m_alt == ALT_RG) ? 2 : 4;
			m_on = 16'(int'(c_on) * k);
			m_cyc = 16'(int'(c_cyc) * k);
		end else if (q.rate == RATE_NORMAL) begin
			m_on = {2'b00, c_on};
			m_cyc = (q.times == SOLID) ? {2'b00, c_on} : {2'b00, c_cyc};
		end else if (q.rate == RATE_QUICK) begin
			m_on = {2'b00, c_on} >> 2;
			m_cyc = {2'b00, c_cyc} >> 2;
		end
		if (q.times == SOLID)
			m_gap = 16'd0;
		else if (q.times == 8'd1)
			m_gap = GAP_SINGLE;
		else if (4'(p) == PROF_BOOT)
			m_gap = c_gap / 16'd10;
		else
			m_gap = c_gap;
		m_drv = m_lvl;
		m_timer = 16'd0;
		m_phase = PH_ON;
	endfunction

	function automatic void led_rescan(input logic t);
		int p;
		bit found;
		found = 1'b0;
		for (p = 0; p < NUM_PROFILES && !found; p++) begin
			if (m_run[p]) begin
				found = 1'b1;
				if (4'(p) != m_cur)
					led_load(p, t);
			end
		end
		if (!found) begin
			m_cur = NO_PROFILE;
			m_drv = '{16'd0, 16'd0, 16'd0};
		end
	endfunction

	function automatic void led_tick(input logic t);
		prof_t q;
		if (m_timer != 16'hFFFF)
			m_timer = m_timer + 16'd1;
		if (m_cur >= NUM_PROFILES)
			return;
		q = led_table[m_cur];
		if (q.times == SOLID || q.times == 8'd0)
			return;
		case (m_phase)
			PH_ON: begin
				if (m_timer > m_on) begin
					m_drv[0] = 16'd0;
					m_drv[2] = 16'd0;
					m_drv[1] = (m_alt == ALT_RG) ? m_lvl[0] : 16'd0;
					m_left = m_left - 8'd1;
					m_phase = PH_OFF;
				end
			end
			PH_OFF: begin
				if (m_timer > m_cyc) begin
					if (m_left > 8'd0) begin
						m_drv = m_lvl;
						m_phase = PH_ON;
					end else begin
						if (m_alt == ALT_RG)
							m_drv[1] = 16'd0;
						m_left = 8'd0;
						m_phase = PH_GAP;
					end
					m_timer = 16'd0;
				end
			end
			PH_GAP: begin
				if (m_timer > m_gap) begin
					if (q.mode == MODE_ONCE) begin
						m_run[m_cur] = 1'b0;
						led_rescan(t);
					end else begin
						m_drv = m_lvl;
						m_left = q.times;
						m_timer = 16'd0;
						m_phase = PH_ON;
					end
				end
			end
			default: ;
		endcase
	endfunction

	function automatic led_out_t led_step(input logic o, input logic [3:0] id,
			input logic en, input logic t);
		if (o == OP_TICK) begin
			led_tick(t);
		end else begin
			if (id < NUM_PROFILES)
				m_run[id] = en;
			led_rescan(t);
		end
		return '{m_drv[0], m_drv[1], m_drv[2], m_cur};
	endfunction

	task automatic send_led_txn(input logic o, input logic [3:0] id, input logic en,
			input logic t);
		int pause;
		if (burst_left == 0) begin
			pause = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (pause > 0) begin
				item_valid <= 1'b0;
				repeat (pause) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 12);
		end
		burst_left--;
		item_valid <= 1'b1;
		op <= o;
		profile_id <= id;
		enable <= en;
		test_button_active <= t;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		expected_leds.push_back(led_step(o, id, en, t));
	endtask

	task automatic send_led_event(input int id, input logic en, input logic t);
		send_led_txn(OP_EVENT, 4'(id), en, t);
	endtask

	task automatic send_led_tick();
		send_led_txn(OP_TICK, 4'($urandom), 1'($urandom), 1'($urandom));
	endtask

	task automatic settle_pipeline();
		item_valid <= 1'b0;
		while (expected_leds.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write_reg(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_ON_TICKS:    c_on = val[13:0];
			REG_CYCLE_TICKS: c_cyc = val[13:0];
			REG_GAP_TICKS:   c_gap = val[15:0];
			REG_BRIGHTNESS:  c_bright = val[15:0];
			default: ;
		endcase
	endtask

	// upper bits carry junk that the register must drop
	task automatic program_led_timing(input logic [13:0] on_t, input logic [13:0] cyc_t,
			input logic [15:0] gap_t, input logic [15:0] bright);
		settle_pipeline();
		apb_write_reg(REG_ON_TICKS, {18'($urandom_range(0, 262143)), on_t});
		apb_write_reg(REG_CYCLE_TICKS, {18'($urandom_range(0, 262143)), cyc_t});
		apb_write_reg(REG_GAP_TICKS, {16'($urandom), gap_t});
		apb_write_reg(REG_BRIGHTNESS, {16'($urandom), bright});
	endtask

	task automatic test_power_on();
		send_led_tick();
		send_led_event(15, 1'b1, 1'b0);
		send_led_event(11, 1'b0, 1'b1);
	endtask

	task automatic test_profile_load();
		program_led_timing(14'd1, 14'd2, 16'd3, 16'hFFFF);
		send_led_event(10, 1'b1, 1'b0);
		send_led_event(9, 1'b1, 1'b0);
		send_led_event(9, 1'b1, 1'b1);
		send_led_event(8, 1'b1, 1'b0);
		send_led_event(7, 1'b1, 1'b0);
		send_led_tick();
		send_led_event(1, 1'b1, 1'b0);
		repeat (3) send_led_tick();
		send_led_event(0, 1'b1, 1'b1);
		send_led_event(0, 1'b0, 1'b0);
		send_led_event(0, 1'b1, 1'b0);
	endtask

	task automatic test_config_extremes();
		program_led_timing(14'h3FFF, 14'h3FFF, 16'hFFFF, 16'hFFFF);
		send_led_event(0, 1'b0, 1'b0);
		send_led_tick();
		send_led_event(1, 1'b0, 1'b0);
		send_led_event(7, 1'b0, 1'b0);
		send_led_event(0, 1'b1, 1'b1);
	endtask

	// boot profile runs its four quick blinks and gap, then drops out on its own
	task automatic test_once_mode();
		program_led_timing(14'd0, 14'd0, 16'd0, 16'($urandom));
		send_led_event(0, 1'b0, 1'b0);
		send_led_event(0, 1'b1, 1'b0);
		repeat (11) send_led_tick();
	endtask

	task automatic test_random_traffic();
		int phase;
		int sent;
		int p;
		int n;
		int k;
		for (phase = 0; phase < 6; phase++) begin
			program_led_timing(14'($urandom_range(0, (phase == 5) ? 40 : 6)),
				14'($urandom_range(0, 12)), 16'($urandom_range(0, (phase == 4) ? 200 : 40)),
				16'($urandom));
			sent = 0;
			while (sent < 190) begin
				k = $urandom_range(0, 9);
				if (k < 6) begin
					p = $urandom_range(0, NUM_PROFILES - 1);
					send_led_event(p, 1'b1, 1'($urandom));
					sent++;
					n = $urandom_range(4, 40);
					repeat (n) begin
						if ($urandom_range(0, 11) == 0)
							send_led_event($urandom_range(0, 15), 1'($urandom), 1'($urandom));
						else
							send_led_tick();
						sent++;
					end
					if ($urandom_range(0, 1)) begin
						send_led_event(p, 1'b0, 1'($urandom));
						sent++;
					end
				end else if (k < 8) begin
					send_led_event($urandom_range(0, 15), 1'($urandom), 1'($urandom));
					sent++;
				end else begin
					for (p = 0; p < NUM_PROFILES; p++) begin
						if (m_run[p]) begin
							send_led_event(p, 1'b0, 1'($urandom));
							sent++;
						end
					end
					send_led_tick();
					sent++;
				end
			end
		end
	endtask

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(5, 60);
		end
		stall_left--;
		case (stall_mode)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 3) == 0);
			2: result_stall <= 1'($urandom);
			default: result_stall <= ($urandom_range(0, 4) != 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (expected_leds.size() == 0) begin
				$error("result transaction with no expectation pending");
				fail_count++;
			end else begin
				want = expected_leds.pop_front();
				if (pwm_red !== want.red) begin
					$error("pwm_red: expected %0d, actual %0d", want.red, pwm_red);
					fail_count++;
				end
				if (pwm_green !== want.green) begin
					$error("pwm_green: expected %0d, actual %0d", want.green, pwm_green);
					fail_count++;
				end
				if (pwm_blue !== want.blue) begin
					$error("pwm_blue: expected %0d, actual %0d", want.blue, pwm_blue);
					fail_count++;
				end
				if (active_profile !== want.profile) begin
					$error("active_profile: expected %0d, actual %0d", want.profile,
						active_profile);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_power_on();
		test_profile_load();
		test_config_extremes();
		test_once_mode();
		test_random_traffic();
		settle_pipeline();
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
